>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each check is compiled in simulation and left empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ACMS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acms check failed");

// Next-cycle implication.
`define ACMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acms check failed");

`else

`define ACMS_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define ACMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/acms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acms_pkg;

   // Store geometry
   localparam int BONE_COUNT         = 32;
   localparam int FRAME_COUNT        = 64;
   localparam int ELEM_COUNT         = 16;
   localparam int TIME_FRACTION_BITS = 8;

   // Field widths
   localparam int BONE_W  = 5;
   localparam int FRAME_W = 6;
   localparam int SLOT_W  = 4;
   localparam int VALUE_W = 32;
   localparam int TIME_W  = 24;
   localparam int ADJ_W   = 23;
   localparam int CLIP_W  = 7;

   // Derived widths
   localparam int BONE_IDX_W   = $clog2(BONE_COUNT);
   localparam int FRAME_IDX_W  = $clog2(FRAME_COUNT);
   localparam int STORE_DEPTH  = BONE_COUNT * FRAME_COUNT * ELEM_COUNT;
   localparam int STORE_ADDR_W = BONE_IDX_W + FRAME_IDX_W + SLOT_W;
   localparam int TF_W         = CLIP_W + TIME_FRACTION_BITS;
   localparam int FLOOR_W      = ADJ_W - TIME_FRACTION_BITS;
   localparam int MOD_CNT_W    = $clog2(ADJ_W);

   // Blend weight: 8 fraction bits, one extra bit to hold exactly 1.0
   localparam int WEIGHT_SHIFT = 8;
   localparam int WEIGHT_W     = WEIGHT_SHIFT + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_SHIFT);

   // Configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CLIP_W;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_FRAMES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE = 1'b1;

   // Item actions
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SETUP,
      ST_STREAM,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                      action;
      logic [BONE_W-1:0]         bone_id;
      logic [FRAME_W-1:0]        frame_number;
      logic [SLOT_W-1:0]         element_slot;
      logic signed [VALUE_W-1:0] write_value;
      logic signed [TIME_W-1:0]  sample_time;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         element_index;
      logic signed [VALUE_W-1:0] blended_value;
      logic [ADJ_W-1:0]          adjusted_time;
      logic                      last_element;
   } rsp_item_type;

   // Travels alongside the store read data through the blend pipeline
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] index;
      logic              last;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/acms_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module acms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/acms_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module acms_blend
   import acms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pipe_ctrl_type        rd_ctrl,
   input  wire logic [VALUE_W-1:0]   front_data,
   input  wire logic [VALUE_W-1:0]   back_data,
   input  wire logic [WEIGHT_W-1:0]  weight,
   input  wire logic [ADJ_W-1:0]     adj_time,
   output logic                      rsp_valid,
   output rsp_item_type              rsp_item
);

   localparam int DIFF_W = VALUE_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [WEIGHT_W:0]   weight_s;
   logic signed [PROD_W-1:0]   product_in;
   logic signed [PROD_W-1:0]   product_ff;
   logic [VALUE_W-1:0]         front_ff;
   pipe_ctrl_type              ctrl_mul_ff;
   logic [VALUE_W-1:0]         blended_in;
   logic                       rsp_valid_ff;
   rsp_item_type               rsp_item_ff;

   // a*(1-w) + b*w == a + (b-a)*w, so one multiplier per element
   always_comb begin
      diff       = $signed({back_data[VALUE_W-1], back_data})
                 - $signed({front_data[VALUE_W-1], front_data});
      weight_s   = $signed({1'b0, weight});
      product_in = diff * weight_s;
   end

   // multiply stage
   always_ff @(posedge clock) begin
      product_ff <= product_in;
      front_ff   <= front_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_mul_ff <= '0;
      end else begin
         ctrl_mul_ff <= rd_ctrl;
      end
   end

   // floor of product/256 is an arithmetic shift; sum wraps at 32 bits
   assign blended_in = front_ff + product_ff[WEIGHT_SHIFT +: VALUE_W];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_mul_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.element_index <= ctrl_mul_ff.index;
      rsp_item_ff.blended_value <= blended_in;
      rsp_item_ff.adjusted_time <= adj_time;
      rsp_item_ff.last_element  <= ctrl_mul_ff.last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

>>> rtl/animation_clip_matrix_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// Write item: stored in the cycle it is accepted, busy stays low, one write per cycle while no sample is in progress.
// Sample item: a bit-serial remainder state first when looping time lies beyond the clip,
// then setup, stream and drain states that deliver its 16 elements.
// Elements leave one per cycle, paced by the single read port of each store copy.
// Synchronous reset clears control and configuration; the matrix store is not cleared.
// Results are strobed for one cycle each; the receiver cannot stall.

`include "assert_macros.svh"

module animation_clip_matrix_sampler
   import acms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_item_type          req_item,
   output logic                       rsp_valid,
   output rsp_item_type               rsp_item,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   state_type state_ff, state_in;

   logic [CLIP_W-1:0]       clip_frames_ff;
   logic                    loop_enable_ff;

   logic [BONE_IDX_W-1:0]   bone_ff;
   logic [ADJ_W-1:0]        t_ff;
   logic [TF_W-1:0]         rem_ff;
   logic [MOD_CNT_W-1:0]    cnt_ff;
   logic [FRAME_IDX_W-1:0]  front_ff;
   logic [FRAME_IDX_W-1:0]  back_ff;
   logic [WEIGHT_W-1:0]     weight_ff;
   logic [ADJ_W-1:0]        adj_ff;
   logic [SLOT_W-1:0]       k_ff;
   pipe_ctrl_type           ctrl_rd_ff;

   logic                    accept;
   logic                    sample_accept;
   logic                    mod_step;
   logic                    setup;
   logic                    issue;
   logic [CLIP_W-1:0]       clip_eff;
   logic [CLIP_W-1:0]       clip_m1;
   logic [TF_W-1:0]         tf;
   logic [ADJ_W-1:0]        time_pos;
   logic                    need_mod;
   logic [BONE_IDX_W-1:0]   bone_clamped;
   logic [TF_W:0]           trial;
   logic [TF_W-1:0]         rem_in;
   logic [FRAME_IDX_W-1:0]  setup_front;
   logic [FRAME_IDX_W-1:0]  setup_back;
   logic [WEIGHT_W-1:0]     setup_weight;
   logic [ADJ_W-1:0]        setup_adj;
   logic                    ram_wr_en;
   logic [STORE_ADDR_W-1:0] ram_wr_addr;
   logic [STORE_ADDR_W-1:0] front_addr;
   logic [STORE_ADDR_W-1:0] back_addr;
   logic [VALUE_W-1:0]      front_data;
   logic [VALUE_W-1:0]      back_data;

   // time fraction rescaled to a weight with 8 fraction bits
   function automatic logic [WEIGHT_W-1:0] frac_to_weight(
      input logic [TIME_FRACTION_BITS-1:0] frac
   );
      logic [TIME_FRACTION_BITS+WEIGHT_SHIFT-1:0] wide;
      wide = {frac, {WEIGHT_SHIFT{1'b0}}};
      return WEIGHT_W'(wide >> TIME_FRACTION_BITS);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_frames_ff <= CLIP_W'(1);
         loop_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLIP_FRAMES: clip_frames_ff <= csr_write_data;
            CSR_LOOP_ENABLE: loop_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // clip length clamped to 1..FRAME_COUNT, scaled to the time format
   always_comb begin
      if (clip_frames_ff == '0) begin
         clip_eff = CLIP_W'(1);
      end else if (clip_frames_ff > CLIP_W'(FRAME_COUNT)) begin
         clip_eff = CLIP_W'(FRAME_COUNT);
      end else begin
         clip_eff = clip_frames_ff;
      end
      clip_m1 = clip_eff - CLIP_W'(1);
      tf      = {clip_eff, {TIME_FRACTION_BITS{1'b0}}};
   end

   // request decode
   assign accept        = start & ~busy;
   assign sample_accept = accept & (req_item.action == ACT_SAMPLE);
   assign time_pos      = req_item.sample_time[TIME_W-1] ? '0
                                                          : req_item.sample_time[ADJ_W-1:0];
   assign need_mod      = loop_enable_ff & (time_pos > ADJ_W'(tf));
   assign bone_clamped  = (req_item.bone_id >= BONE_COUNT)
                        ? BONE_IDX_W'(BONE_COUNT - 1)
                        : req_item.bone_id[BONE_IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_accept) begin
               state_in = need_mod ? ST_MOD : ST_SETUP;
            end
         end
         ST_MOD: begin
            if (cnt_ff == '0) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if (k_ff == SLOT_W'(ELEM_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_item.last_element) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy     = 1'b1;
      mod_step = 1'b0;
      setup    = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   busy     = 1'b0;
         ST_MOD:    mod_step = 1'b1;
         ST_SETUP:  setup    = 1'b1;
         ST_STREAM: issue    = 1'b1;
         ST_DRAIN:  ;
         default:   busy     = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // remainder unit: one time bit per cycle, compare and subtract
   always_comb begin
      trial = {rem_ff, t_ff[ADJ_W-1]};
      if (trial >= {1'b0, tf}) begin
         rem_in = TF_W'(trial - {1'b0, tf});
      end else begin
         rem_in = trial[TF_W-1:0];
      end
   end

   // frame pair, weight and reported time
   always_comb begin
      logic [FLOOR_W-1:0]            floor_t;
      logic [TIME_FRACTION_BITS-1:0] frac;
      floor_t = t_ff[ADJ_W-1:TIME_FRACTION_BITS];
      frac    = t_ff[TIME_FRACTION_BITS-1:0];
      if (loop_enable_ff) begin
         if (t_ff == ADJ_W'(tf)) begin
            // exactly at the clip end: fully frame 0
            setup_front  = FRAME_IDX_W'(clip_m1);
            setup_back   = '0;
            setup_weight = WEIGHT_ONE;
            setup_adj    = '0;
         end else begin
            setup_front  = FRAME_IDX_W'(floor_t);
            setup_back   = (floor_t < FLOOR_W'(clip_m1))
                         ? FRAME_IDX_W'(floor_t) + FRAME_IDX_W'(1) : '0;
            setup_weight = frac_to_weight(frac);
            setup_adj    = t_ff;
         end
      end else begin
         if (floor_t < FLOOR_W'(clip_m1)) begin
            setup_front  = FRAME_IDX_W'(floor_t);
            setup_back   = FRAME_IDX_W'(floor_t) + FRAME_IDX_W'(1);
            setup_weight = frac_to_weight(frac);
         end else begin
            // hold the last frame
            setup_front  = FRAME_IDX_W'(clip_m1);
            setup_back   = FRAME_IDX_W'(clip_m1);
            setup_weight = '0;
         end
         setup_adj = (t_ff > ADJ_W'(tf)) ? ADJ_W'(tf) : t_ff;
      end
   end

   // sample datapath registers
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         bone_ff <= bone_clamped;
         t_ff    <= time_pos;
         rem_ff  <= '0;
         cnt_ff  <= MOD_CNT_W'(ADJ_W - 1);
      end
      if (mod_step) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - MOD_CNT_W'(1);
         t_ff   <= (cnt_ff == '0) ? ADJ_W'(rem_in) : {t_ff[ADJ_W-2:0], 1'b0};
      end
      if (setup) begin
         front_ff  <= setup_front;
         back_ff   <= setup_back;
         weight_ff <= setup_weight;
         adj_ff    <= setup_adj;
         k_ff      <= '0;
      end
      if (issue) begin
         k_ff <= k_ff + SLOT_W'(1);
      end
   end

   // control aligned with the registered store read
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_rd_ff <= '0;
      end else begin
         ctrl_rd_ff.valid <= issue;
         ctrl_rd_ff.index <= k_ff;
         ctrl_rd_ff.last  <= (k_ff == SLOT_W'(ELEM_COUNT - 1));
      end
   end

   // store addressing; both copies take every write
   assign ram_wr_en   = accept & (req_item.action == ACT_WRITE)
                      & (req_item.bone_id < BONE_COUNT)
                      & (req_item.frame_number < FRAME_COUNT);
   assign ram_wr_addr = {req_item.bone_id[BONE_IDX_W-1:0],
                         req_item.frame_number[FRAME_IDX_W-1:0],
                         req_item.element_slot};
   assign front_addr  = {bone_ff, front_ff, k_ff};
   assign back_addr   = {bone_ff, back_ff, k_ff};

   acms_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_front (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item.write_value),
      .rd_addr (front_addr),
      .rd_data (front_data)
   );

   acms_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_back (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item.write_value),
      .rd_addr (back_addr),
      .rd_data (back_data)
   );

   acms_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .rd_ctrl    (ctrl_rd_ff),
      .front_data (front_data),
      .back_data  (back_data),
      .weight     (weight_ff),
      .adj_time   (adj_ff),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // checks
   `ACMS_ASSERT_HOLDS(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ACMS_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_item.last_element, !busy)
   `ACMS_ASSERT_NEXT(a_index_steps, clock, reset, rsp_valid && !rsp_item.last_element, rsp_valid && (rsp_item.element_index == SLOT_W'($past(rsp_item.element_index) + SLOT_W'(1))))
   `ACMS_ASSERT_HOLDS(a_rem_below_tf, clock, reset, state_ff == ST_MOD, rem_ff < tf)

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import acms_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS   = 34;
   localparam int PHASE_COUNT   = 9;
   localparam int REPORT_CAP    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   rsp_item_type          rsp_item;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   animation_clip_matrix_sampler DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Items waiting to be driven, and blended elements still to arrive
   req_item_type item_queue [$];
   rsp_item_type expected_elements [$];

   // Shadow of the matrix table and of the clip registers
   logic [VALUE_W-1:0]    matrix_shadow [STORE_DEPTH];
   logic [ELEM_COUNT-1:0] loaded_mask [BONE_COUNT*FRAME_COUNT];
   logic [CLIP_W-1:0]     clip_len = 7'd1;
   logic                  loop_mode = 1'b0;

   int idle_pct = 0;
   int items_queued = 0;
   int items_accepted = 0;
   int samples_accepted = 0;
   int elements_checked = 0;
   int mismatches = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Clip length as the block sees it: 0 acts as 1, long clips cap at the table
   function automatic int eff_frames(logic [CLIP_W-1:0] clip);
      if (clip == 0) return 1;
      if (clip > FRAME_COUNT) return FRAME_COUNT;
      return int'(clip);
   endfunction

   function automatic int store_addr(int bone, int frame, int slot);
      return (bone * FRAME_COUNT + frame) * ELEM_COUNT + slot;
   endfunction

   // Clamp/wrap the time and pick front frame, back frame and weight
   function automatic void resolve_time(input logic signed [TIME_W-1:0] st, input int d,
                                        input logic looping, output int front,
                                        output int back, output int weight,
                                        output logic [ADJ_W-1:0] adj);
      longint t;
      longint tf;
      t = 0;
      if (st > 0) t = st;
      tf = longint'(d) << TIME_FRACTION_BITS;
      if (looping) begin
         if (t > tf) t = t % tf;
         if (t == tf) begin
            // exactly at the end: fully blended toward frame 0
            front  = d - 1;
            back   = 0;
            weight = 1 << WEIGHT_SHIFT;
            adj    = '0;
         end else begin
            front  = int'(t >> TIME_FRACTION_BITS);
            back   = (front < d - 1) ? front + 1 : 0;
            weight = int'(t & ((1 << TIME_FRACTION_BITS) - 1));
            adj    = ADJ_W'(t);
         end
      end else begin
         front = int'(t >> TIME_FRACTION_BITS);
         if (front < d - 1) begin
            back   = front + 1;
            weight = int'(t & ((1 << TIME_FRACTION_BITS) - 1));
         end else begin
            // hold the last frame
            front  = d - 1;
            back   = front;
            weight = 0;
         end
         adj = (t > tf) ? ADJ_W'(tf) : ADJ_W'(t);
      end
   endfunction

   // a*(256-w) + b*w, floored back to Q16.16
   function automatic logic [VALUE_W-1:0] blend_element(logic [VALUE_W-1:0] a,
                                                        logic [VALUE_W-1:0] b, int w);
      longint v;
      v = longint'(signed'(a)) * longint'((1 << WEIGHT_SHIFT) - w)
        + longint'(signed'(b)) * longint'(w);
      return VALUE_W'(v >>> WEIGHT_SHIFT);
   endfunction

   // Apply one accepted item to the shadow table; samples queue 16 elements
   function automatic void predict_item(req_item_type it);
      int front;
      int back;
      int weight;
      logic [ADJ_W-1:0] adj;
      rsp_item_type want;
      if (it.action == ACT_WRITE) begin
         matrix_shadow[store_addr(it.bone_id, it.frame_number, it.element_slot)] =
            it.write_value;
      end else begin
         samples_accepted++;
         resolve_time(it.sample_time, eff_frames(clip_len), loop_mode, front, back, weight,
                      adj);
         for (int k = 0; k < ELEM_COUNT; k++) begin
            want.element_index = SLOT_W'(k);
            want.blended_value = blend_element(
               matrix_shadow[store_addr(it.bone_id, front, k)],
               matrix_shadow[store_addr(it.bone_id, back, k)], weight);
            want.adjusted_time = adj;
            want.last_element  = (k == ELEM_COUNT - 1);
            expected_elements.push_back(want);
         end
      end
   endfunction

   function automatic void compare_field(string field, logic [VALUE_W-1:0] want,
                                         logic [VALUE_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   // Driver: present the next item, or idle, once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_item(req_item);
            items_accepted++;
         end
         if (!start || !busy) begin
            if (item_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               start    <= 1'b1;
               req_item <= item_queue.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed element against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_elements.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: element with nothing expected, expected none, got %p",
                        $time, rsp_item);
         end else begin
            rsp_item_type want;
            want = expected_elements.pop_front();
            elements_checked++;
            compare_field("element_index", want.element_index, rsp_item.element_index);
            compare_field("blended_value", want.blended_value, rsp_item.blended_value);
            compare_field("adjusted_time", want.adjusted_time, rsp_item.adjusted_time);
            compare_field("last_element", want.last_element, rsp_item.last_element);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("animation_clip_matrix_sampler regression: fail");
         $finish;
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Times biased toward frame edges, the clip end, negatives and far beyond
   function automatic logic signed [TIME_W-1:0] pick_time(int d);
      int tf;
      int roll;
      int t;
      tf   = d << TIME_FRACTION_BITS;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         t = ($urandom_range(0, 3) == 0) ? -8388608 : -int'($urandom_range(1, 4000));
      else if (roll < 17)
         t = tf;
      else if (roll < 27)
         t = ($urandom_range(0, 4) == 0) ? 8388607 : tf + 1 + int'($urandom_range(0, 8388606 - tf));
      else if (roll < 37)
         t = int'($urandom_range(0, d - 1)) << TIME_FRACTION_BITS;
      else if (roll < 70)
         t = (int'($urandom_range(0, ((d < 4) ? d : 4) - 1)) << TIME_FRACTION_BITS)
           + int'($urandom_range(0, 255));
      else
         t = (int'($urandom_range(0, d - 1)) << TIME_FRACTION_BITS) + int'($urandom_range(0, 255));
      return TIME_W'(t);
   endfunction

   // Random filler for the fields an item does not use
   function automatic req_item_type random_item();
      logic [$bits(req_item_type)-1:0] raw;
      raw = {$urandom, $urandom, 8'($urandom)};
      return raw;
   endfunction

   function automatic void queue_item(req_item_type it);
      if (it.action == ACT_WRITE)
         loaded_mask[it.bone_id * FRAME_COUNT + it.frame_number][it.element_slot] = 1'b1;
      item_queue.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_write(int bone, int frame, int slot, logic [VALUE_W-1:0] value);
      req_item_type it;
      it              = random_item();
      it.action       = ACT_WRITE;
      it.bone_id      = BONE_W'(bone);
      it.frame_number = FRAME_W'(frame);
      it.element_slot = SLOT_W'(slot);
      it.write_value  = value;
      queue_item(it);
   endfunction

   // Load a whole matrix, elements in shuffled order, unless already complete
   function automatic void load_frame(int bone, int frame);
      int order [ELEM_COUNT];
      int j;
      int tmp;
      if (&loaded_mask[bone * FRAME_COUNT + frame]) return;
      for (int i = 0; i < ELEM_COUNT; i++) order[i] = i;
      for (int i = ELEM_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < ELEM_COUNT; i++) queue_write(bone, frame, order[i], pick_value());
   endfunction

   function automatic void queue_sample(int bone, logic signed [TIME_W-1:0] t);
      int front;
      int back;
      int weight;
      logic [ADJ_W-1:0] adj;
      req_item_type it;
      resolve_time(t, eff_frames(clip_len), loop_mode, front, back, weight, adj);
      load_frame(bone, front);
      load_frame(bone, back);
      it             = random_item();
      it.action      = ACT_SAMPLE;
      it.bone_id     = BONE_W'(bone);
      it.sample_time = t;
      queue_item(it);
   endfunction

   task automatic program_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == CSR_CLIP_FRAMES) clip_len = data;
      else loop_mode = data[0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Block idle: everything taken, every element seen, then settle
   task automatic wait_for_drain();
      while (items_accepted != items_queued || expected_elements.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int bone_pool [3];
      int clip;
      int looping;
      int phase_start;
      int bone;
      int frame;
      foreach (loaded_mask[i]) loaded_mask[i] = '0;
      foreach (bone_pool[i]) bone_pool[i] = $urandom_range(0, BONE_COUNT - 1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-frame looping clip, extreme element values and times
      program_register(CSR_CLIP_FRAMES, 7'd1);
      program_register(CSR_LOOP_ENABLE, 7'd1);
      queue_write(31, 0, 0, 32'h8000_0000);
      queue_write(31, 0, 1, 32'h7FFF_FFFF);
      queue_write(31, 0, 2, 32'h0000_0000);
      queue_write(31, 0, 3, 32'hFFFF_FFFF);
      queue_write(31, 0, 4, 32'h0001_0000);
      queue_write(31, 0, 5, 32'hFFFF_0000);
      queue_write(31, 0, 6, 32'h0000_0001);
      queue_write(31, 0, 7, 32'h8000_0001);
      for (int s = 8; s < ELEM_COUNT; s++) queue_write(31, 0, s, $urandom);
      queue_sample(31, -24'sd8388608);
      queue_sample(31, 24'sd0);
      queue_sample(31, 24'sd128);
      queue_sample(31, 24'sd256);
      queue_sample(31, 24'sd300);
      queue_sample(31, 24'sd8388607);
      wait_for_drain();

      // Random phases over clip settings and sender idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin clip = 2;   looping = 0; end
            1: begin clip = 64;  looping = 1; end
            2: begin clip = 0;   looping = 1; end
            3: begin clip = 127; looping = 0; end
            4: begin clip = 1;   looping = 0; end
            5: begin clip = $urandom_range(3, 63); looping = 1; end
            6: begin clip = $urandom_range(3, 127); looping = 0; end
            7: begin clip = 64;  looping = 0; end
            default: begin clip = 5; looping = 1; end
         endcase
         program_register(CSR_CLIP_FRAMES, CSR_DATA_W'(clip));
         program_register(CSR_LOOP_ENABLE, {(CSR_DATA_W-1)'($urandom), 1'(looping)});
         idle_pct = (p < 3) ? 15 : (p < 6) ? 46 : 0;

         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               // stray writes, often leaving a matrix half loaded
               bone  = $urandom_range(0, BONE_COUNT - 1);
               frame = $urandom_range(0, FRAME_COUNT - 1);
               repeat ($urandom_range(1, 5))
                  queue_write(bone, frame, $urandom_range(0, ELEM_COUNT - 1), pick_value());
            end else begin
               bone = ($urandom_range(0, 99) < 85) ? bone_pool[$urandom_range(0, 2)]
                                                    : $urandom_range(0, BONE_COUNT - 1);
               queue_sample(bone, pick_time(eff_frames(clip_len)));
            end
         end
         wait_for_drain();
      end

      $display("%0d items accepted, %0d of them samples; %0d blended elements checked",
               items_accepted, samples_accepted, elements_checked);
      $display("clip lengths 0 to 127 in loop and clamp mode, sender idling 0/15/46 percent");
      if (mismatches == 0 && expected_elements.size() == 0) begin
         $display("animation_clip_matrix_sampler regression: pass");
      end else begin
         $display("animation_clip_matrix_sampler regression: fail");
      end
      $finish;
   end

endmodule
